[sv/dvmc_pkg.sv]
// Shared types and constants for the deadzone and vector magnitude clamp.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dvmc_pkg;

	localparam int unsigned AXES = 3;
	localparam int unsigned AXIS_W = 16;
	localparam int unsigned MAG_W = AXIS_W + 1;
	localparam int unsigned SUM_W = 32;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned REM0_W = 31;
	localparam int unsigned QUO_W = 16;

	localparam logic [AXIS_W-1:0] LIMIT_MAG = 16'd32767;
	localparam logic [SUM_W-1:0] LIMIT_SQ = 32'd1073676289;
	localparam logic [AXIS_W-1:0] DEADZONE_RESET = 16'd4000;

	typedef struct packed {
		logic signed [15:0] x_axis_in;
		logic signed [15:0] y_axis_in;
		logic signed [15:0] z_axis_in;
		logic signed [15:0] heading_in;
	} in_t;

	typedef struct packed {
		logic signed [15:0] x_thrust;
		logic signed [15:0] y_thrust;
		logic signed [15:0] z_thrust;
		logic signed [15:0] heading_thrust;
		logic was_scaled;
	} out_t;

	// What travels beside the square root and the dividers.
	typedef struct packed {
		logic [AXES-1:0] neg;
		logic [AXES-1:0][AXIS_W-1:0] ax;
		logic scaled;
		logic [AXIS_W-1:0] heading;
	} side_t;

endpackage

`default_nettype wire

[sv/deadzone_vector_magnitude_clamp.sv]
// Joystick deadzone and vector magnitude clamp: top level.
// Instantiates dvmc_sqrt and dvmc_div; depends on dvmc_pkg.
// The block takes one sample per cycle while not stalled; a sample passes through
// three front stages (deadzone, squares, sum), 32 square-root stages, 16
// divider stages and an output register. The single stall signal holds the
// whole pipeline while a finished word waits at the output, so in_stall is high
// exactly when out_valid is high and out_stall is asserted. The deadzone
// register is written through the cfg channel, which is always ready.
`default_nettype none

module deadzone_vector_magnitude_clamp
	import dvmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_t             out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned SIDE_W = $bits(side_t);
	localparam int unsigned DSIDE_W = SIDE_W + AXES * REM0_W;

	logic adv;
	logic [AXIS_W-1:0] deadzone_q;

	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= DEADZONE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			deadzone_q <= cfg_data;
		end
	end

	// Stage 1: magnitudes and deadzone.
	logic [AXES-1:0][AXIS_W-1:0] raw;
	logic [AXES-1:0][AXIS_W-1:0] ax_c;
	logic [AXES-1:0][MAG_W-1:0]  mag_c;
	logic [AXES-1:0]             neg_c;

	assign raw[0] = in_data.x_axis_in;
	assign raw[1] = in_data.y_axis_in;
	assign raw[2] = in_data.z_axis_in;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			if (raw[i][AXIS_W-1]) begin
				mag_c[i] = MAG_W'(0) - {1'b1, raw[i]};
			end else begin
				mag_c[i] = {1'b0, raw[i]};
			end
			neg_c[i] = raw[i][AXIS_W-1];
			ax_c[i] = raw[i];
			if (mag_c[i] < {1'b0, deadzone_q}) begin
				mag_c[i] = '0;
				neg_c[i] = 1'b0;
				ax_c[i] = '0;
			end
		end
	end

	logic                        valid_s1, valid_s2, valid_s3;
	logic [AXES-1:0][MAG_W-1:0]  mag_s1;
	side_t                       side_s1, side_s2, side_s3;
	logic [AXES-1:0][SUM_W-1:0]  sq_s2;
	logic [AXES-1:0][REM0_W-1:0] rem0_s2, rem0_s3;
	logic [SUM_W-1:0]            sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag_c;
			side_s1.neg <= neg_c;
			side_s1.ax <= ax_c;
			side_s1.scaled <= 1'b0;
			side_s1.heading <= in_data.heading_in;

			// Stage 2: squares, and magnitude times the limit as the
			// dividers' starting remainder.
			for (int i = 0; i < AXES; i++) begin
				sq_s2[i] <= SUM_W'(mag_s1[i] * mag_s1[i]);
				rem0_s2[i] <= REM0_W'({mag_s1[i], 15'd0} - {15'd0, mag_s1[i]});
			end
			side_s2 <= side_s1;

			// Stage 3: sum of squares and the limit test.
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			rem0_s3 <= rem0_s2;
			side_s3.neg <= side_s2.neg;
			side_s3.ax <= side_s2.ax;
			side_s3.heading <= side_s2.heading;
			side_s3.scaled <= (sq_s2[0] + sq_s2[1] + sq_s2[2]) > LIMIT_SQ;
		end
	end

	logic                     sq_valid;
	logic [ROOT_W-1:0]        root_len;
	logic [DSIDE_W-1:0]       sq_side;
	logic                     dv_valid;
	logic [AXES-1:0][QUO_W-1:0] quo;
	side_t                    dv_side;

	dvmc_sqrt #(
		.SW(DSIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (valid_s3),
		.in_rad   (sum_s3),
		.in_side  ({rem0_s3, side_s3}),
		.out_valid(sq_valid),
		.out_root (root_len),
		.out_side (sq_side)
	);

	dvmc_div #(
		.SW(SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (sq_valid),
		.in_den   (root_len),
		.in_rem   (sq_side[DSIDE_W-1:SIDE_W]),
		.in_side  (sq_side[SIDE_W-1:0]),
		.out_valid(dv_valid),
		.out_quo  (quo),
		.out_side (dv_side)
	);

	// Output stage: saturate, reapply sign, or pass the deadzoned axis.
	logic [AXES-1:0][AXIS_W-1:0] res_c;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			logic [QUO_W-1:0] q;
			q = (quo[i] > LIMIT_MAG) ? LIMIT_MAG : quo[i];
			if (dv_side.scaled) begin
				res_c[i] = dv_side.neg[i] ? (AXIS_W'(0) - q) : q;
			end else begin
				res_c[i] = dv_side.ax[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.x_thrust <= res_c[0];
			out_data.y_thrust <= res_c[1];
			out_data.z_thrust <= res_c[2];
			out_data.heading_thrust <= dv_side.heading;
			out_data.was_scaled <= dv_side.scaled;
		end
	end

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output word");

	a_scaled_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.was_scaled) |->
		(out_data.x_thrust != 16'sh8000 && out_data.y_thrust != 16'sh8000
		&& out_data.z_thrust != 16'sh8000))
		else $error("scaled axis outside the magnitude limit");

	a_scaled_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.was_scaled) |->
		(out_data.x_thrust != 16'sh0 || out_data.y_thrust != 16'sh0
		|| out_data.z_thrust != 16'sh0))
		else $error("scaled vector collapsed to zero");

endmodule

`default_nettype wire

[sv/dvmc_sqrt.sv]
// Pipelined integer square root of a 32-bit value shifted up by 32 bits.
// One result bit per stage; depends on dvmc_pkg.
`default_nettype none

module dvmc_sqrt
	import dvmc_pkg::*;
#(
	parameter int unsigned SW = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire logic [SUM_W-1:0]  in_rad,
	input  wire logic [SW-1:0]     in_side,
	output logic                   out_valid,
	output logic [ROOT_W-1:0]      out_root,
	output logic [SW-1:0]          out_side
);

	logic [ROOT_W:0]    valid_s;
	logic [33:0]        rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]  root_s [ROOT_W+1];
	logic [SUM_W-1:0]   rad_s  [ROOT_W+1];
	logic [SW-1:0]      side_s [ROOT_W+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = in_rad;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [33:0] rem_sh;
		logic [33:0] trial;
		logic        ge;

		always_comb begin
			rem_sh = {rem_s[k][31:0], rad_s[k][SUM_W-1 -: 2]};
			trial = {root_s[k], 2'b01};
			ge = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				rad_s[k+1] <= {rad_s[k][SUM_W-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[ROOT_W];
	assign out_root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

endmodule

`default_nettype wire

[sv/dvmc_div.sv]
// Pipelined restoring dividers, one lane per axis, one quotient bit per stage.
// The dividend's low 16 bits are zero, so only shifts of the remainder feed in.
// Depends on dvmc_pkg.
`default_nettype none

module dvmc_div
	import dvmc_pkg::*;
#(
	parameter int unsigned SW = 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire logic [ROOT_W-1:0]            in_den,
	input  wire logic [AXES-1:0][REM0_W-1:0]  in_rem,
	input  wire logic [SW-1:0]                in_side,
	output logic                              out_valid,
	output logic [AXES-1:0][QUO_W-1:0]        out_quo,
	output logic [SW-1:0]                     out_side
);

	logic [QUO_W:0]                    valid_s;
	logic [ROOT_W-1:0]                 den_s  [QUO_W+1];
	logic [AXES-1:0][ROOT_W-1:0]       rem_s  [QUO_W+1];
	logic [AXES-1:0][QUO_W-1:0]        quo_s  [QUO_W+1];
	logic [SW-1:0]                     side_s [QUO_W+1];

	assign valid_s[0] = in_valid;
	assign den_s[0] = in_den;
	assign quo_s[0] = '0;
	assign side_s[0] = in_side;
	for (genvar l = 0; l < AXES; l++) begin : g_init
		assign rem_s[0][l] = {1'b0, in_rem[l]};
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [AXES-1:0][ROOT_W:0]     r_sh;
		logic [AXES-1:0]               ge;
		logic [AXES-1:0][ROOT_W-1:0]   rem_nx;
		logic [AXES-1:0][QUO_W-1:0]    quo_nx;

		always_comb begin
			for (int l = 0; l < AXES; l++) begin
				r_sh[l] = {rem_s[k][l], 1'b0};
				ge[l] = (r_sh[l] >= {1'b0, den_s[k]});
				rem_nx[l] = ge[l] ? ROOT_W'(r_sh[l] - {1'b0, den_s[k]})
					: r_sh[l][ROOT_W-1:0];
				quo_nx[l] = {quo_s[k][l][QUO_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				den_s[k+1] <= den_s[k];
				rem_s[k+1] <= rem_nx;
				quo_s[k+1] <= quo_nx;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign out_quo = quo_s[QUO_W];
	assign out_side = side_s[QUO_W];

endmodule

`default_nettype wire
